// ===== src/iou_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iou_pkg;

	// Fraction bits of the fixed-point log2 and the ln 2 constant in Q0.32.
	localparam int LOG_FRAC = 24;
	localparam int MANT_BITS = 32;
	localparam logic [MANT_BITS-1:0] LN2_Q32 = 32'hB17217F8;
	localparam int FRAC_CNT_BITS = $clog2(LOG_FRAC + 1);

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AREA,
		ST_UNION,
		ST_LOG,
		ST_LOGWAIT,
		ST_PROD,
		ST_ACC,
		ST_LAST,
		ST_DIV,
		ST_EMIT
	} ctl_state_t;

	// Phases of the log2 unit.
	typedef enum logic [1:0] {
		LG_IDLE,
		LG_NORM,
		LG_SQ
	} log_phase_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic area;
		logic uni;
		logic log_start;
		logic prod;
		logic acc;
		logic div_start;
		logic out_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip;
		logic last;
		logic log_done;
		logic div_done;
		logic out_full;
		logic out_taken;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== src/iou_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface iou_pix_if #(
	parameter int DIST_BITS = 16
);
	logic valid;
	logic ready;
	logic [DIST_BITS-1:0] pred_top;
	logic [DIST_BITS-1:0] pred_bottom;
	logic [DIST_BITS-1:0] pred_left;
	logic [DIST_BITS-1:0] pred_right;
	logic [DIST_BITS-1:0] truth_top;
	logic [DIST_BITS-1:0] truth_bottom;
	logic [DIST_BITS-1:0] truth_left;
	logic [DIST_BITS-1:0] truth_right;
	logic last_pixel;

	modport source (
		output valid, pred_top, pred_bottom, pred_left, pred_right,
		output truth_top, truth_bottom, truth_left, truth_right, last_pixel,
		input ready
	);
	modport sink (
		input valid, pred_top, pred_bottom, pred_left, pred_right,
		input truth_top, truth_bottom, truth_left, truth_right, last_pixel,
		output ready
	);
endinterface
`default_nettype wire

// ===== src/iou_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface iou_res_if #(
	parameter int COUNT_BITS = 20,
	parameter int LOSS_FRAC_BITS = 16
);
	logic valid;
	logic ready;
	logic [8+LOSS_FRAC_BITS-1:0] mean_loss;
	logic [COUNT_BITS-1:0] pixel_count;

	modport source (output valid, mean_loss, pixel_count, input ready);
	modport sink (input valid, mean_loss, pixel_count, output ready);
endinterface
`default_nettype wire

// ===== src/iou_log2.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iou_log2 #(
	parameter int XW = 35,
	parameter int EW = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [XW-1:0] x,
	output logic done,
	output logic [EW+iou_pkg::LOG_FRAC-1:0] result
);
	import iou_pkg::*;

	localparam int NW = XW + MANT_BITS;

	log_phase_t phase_q;
	logic [NW-1:0] nrm_q;
	logic [EW-1:0] exp_q;
	logic [MANT_BITS-1:0] mant_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [FRAC_CNT_BITS-1:0] step_q;
	logic [2*MANT_BITS-1:0] sq;
	logic [MANT_BITS:0] sq_sh;

	// One squaring of the mantissa per cycle.
	assign sq = mant_q * mant_q;
	assign sq_sh = sq[2*MANT_BITS-1 -: MANT_BITS+1] >> 0;

	// Normalize one bit a cycle, then draw one fraction bit a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= LG_IDLE;
		end else begin
			case (phase_q)
				LG_IDLE: if (start) phase_q <= LG_NORM;
				LG_NORM: if (nrm_q[NW-1]) phase_q <= LG_SQ;
				LG_SQ: if (step_q == FRAC_CNT_BITS'(LOG_FRAC - 1)) phase_q <= LG_IDLE;
				default: phase_q <= LG_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			LG_IDLE: begin
				if (start) begin
					nrm_q <= {((x == '0) ? XW'(1) : x), {MANT_BITS{1'b0}}};
					exp_q <= EW'(XW - 1);
				end
			end
			LG_NORM: begin
				if (nrm_q[NW-1]) begin
					mant_q <= nrm_q[NW-1 -: MANT_BITS];
					step_q <= '0;
				end else begin
					nrm_q <= nrm_q << 1;
					exp_q <= exp_q - EW'(1);
				end
			end
			LG_SQ: begin
				frac_q <= {frac_q[LOG_FRAC-2:0], sq_sh[MANT_BITS]};
				mant_q <= sq_sh[MANT_BITS] ? sq_sh[MANT_BITS:1] : sq_sh[MANT_BITS-1:0];
				step_q <= step_q + FRAC_CNT_BITS'(1);
			end
			default: begin
			end
		endcase
	end

	assign done = (phase_q == LG_IDLE);
	assign result = {exp_q, frac_q};
endmodule
`default_nettype wire

// ===== src/iou_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iou_dp #(
	parameter int DIST_BITS = 16,
	parameter int COUNT_BITS = 20,
	parameter int LOSS_FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire iou_pkg::ctl_cmd_t cmd,
	output iou_pkg::dp_sts_t sts,
	iou_pix_if.sink pixel,
	iou_res_if.source result
);
	import iou_pkg::*;

	localparam int SW = DIST_BITS + 1;
	localparam int AW = 2 * SW;
	localparam int UW = AW + 1;
	localparam int LB = 8 + LOSS_FRAC_BITS;
	localparam int SUMW = LB + COUNT_BITS;
	localparam int EW = $clog2(UW);
	localparam int LW = EW + LOG_FRAC;
	localparam int PW = LW + MANT_BITS;
	localparam int SH = MANT_BITS + LOG_FRAC - LOSS_FRAC_BITS;
	localparam int DCW = $clog2(SUMW + 1);
	localparam int C = COUNT_BITS;

	logic [DIST_BITS-1:0] pt_q, pb_q, pl_q, pr_q, gt_q, gb_q, gl_q, gr_q;
	logic last_q, skip_q;
	logic [AW-1:0] parea_q, garea_q, inter_q;
	logic [UW-1:0] uni_q, uni_raw;
	logic [LW-1:0] lu, li, dlog;
	logic lu_done, li_done;
	logic [PW-1:0] prod_q;
	logic [PW:0] term_full;
	logic [LB-1:0] term;
	logic [SUMW-1:0] sum_q;
	logic [C-1:0] cnt_q, ocnt_q;
	logic [C:0] div_rem_q, div_shift;
	logic [SUMW-1:0] div_quo_q;
	logic [C-1:0] div_den_q;
	logic [DCW-1:0] div_cnt_q;
	logic div_ge;
	logic [LB-1:0] mean_q;
	logic [C-1:0] count_q;
	logic out_full_q;

	// Capture the request and decide up front whether it contributes.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pt_q <= pixel.pred_top;
			pb_q <= pixel.pred_bottom;
			pl_q <= pixel.pred_left;
			pr_q <= pixel.pred_right;
			gt_q <= pixel.truth_top;
			gb_q <= pixel.truth_bottom;
			gl_q <= pixel.truth_left;
			gr_q <= pixel.truth_right;
			last_q <= pixel.last_pixel;
			skip_q <= ((pixel.pred_top | pixel.pred_bottom | pixel.pred_left
				| pixel.pred_right) == '0)
				|| ((pixel.truth_top | pixel.truth_bottom | pixel.truth_left
				| pixel.truth_right) == '0)
				|| (cnt_q == {C{1'b1}});
		end
	end

	// Areas and intersection, three independent products.
	always_ff @(posedge clk) begin
		if (cmd.area) begin
			parea_q <= (SW'(pt_q) + SW'(pb_q)) * (SW'(pl_q) + SW'(pr_q));
			garea_q <= (SW'(gt_q) + SW'(gb_q)) * (SW'(gl_q) + SW'(gr_q));
			inter_q <= (SW'((pt_q < gt_q) ? pt_q : gt_q) + SW'((pb_q < gb_q) ? pb_q : gb_q))
				* (SW'((pl_q < gl_q) ? pl_q : gl_q) + SW'((pr_q < gr_q) ? pr_q : gr_q));
		end
	end

	// Union, floored at one LSB.
	assign uni_raw = UW'(parea_q) + UW'(garea_q) - UW'(inter_q);
	always_ff @(posedge clk) begin
		if (cmd.uni) begin
			uni_q <= (uni_raw == '0) ? UW'(1) : uni_raw;
		end
	end

	iou_log2 #(.XW(UW), .EW(EW)) u_log_uni (
		.clk(clk), .arst_n(arst_n), .start(cmd.log_start),
		.x(uni_q), .done(lu_done), .result(lu)
	);
	iou_log2 #(.XW(UW), .EW(EW)) u_log_inter (
		.clk(clk), .arst_n(arst_n), .start(cmd.log_start),
		.x(UW'(inter_q)), .done(li_done), .result(li)
	);

	// Log difference times ln 2.
	assign dlog = (lu > li) ? (lu - li) : '0;
	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			prod_q <= PW'(dlog) * PW'(LN2_Q32);
		end
	end

	// Round half up, saturate, and pick the maximum for an empty intersection.
	assign term_full = ((PW+1)'(prod_q) + ((PW+1)'(1) << (SH - 1))) >> SH;
	always_comb begin
		if (inter_q == '0 || term_full > (PW+1)'({LB{1'b1}})) begin
			term = {LB{1'b1}};
		end else begin
			term = term_full[LB-1:0];
		end
	end

	// Running sum and count; cleared when the mean is started.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.acc && !skip_q) begin
			sum_q <= sum_q + SUMW'(term);
			cnt_q <= cnt_q + C'(1);
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign div_shift = {div_rem_q[C-1:0], div_quo_q[SUMW-1]};
	assign div_ge = div_shift >= {1'b0, div_den_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DCW'(SUMW);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_quo_q <= sum_q;
			div_den_q <= (cnt_q == '0) ? C'(1) : cnt_q;
			ocnt_q <= cnt_q;
		end else if (div_cnt_q != '0) begin
			div_rem_q <= div_ge ? (div_shift - {1'b0, div_den_q}) : div_shift;
			div_quo_q <= {div_quo_q[SUMW-2:0], div_ge};
		end
	end

	// Output register; holds the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_full_q <= 1'b1;
		end else if (result.ready) begin
			out_full_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_q <= (div_quo_q > SUMW'({LB{1'b1}})) ? {LB{1'b1}} : div_quo_q[LB-1:0];
			count_q <= ocnt_q;
		end
	end

	assign result.valid = out_full_q;
	assign result.mean_loss = mean_q;
	assign result.pixel_count = count_q;

	assign sts.skip = skip_q;
	assign sts.last = last_q;
	assign sts.log_done = lu_done && li_done;
	assign sts.div_done = (div_cnt_q == '0);
	assign sts.out_full = out_full_q;
	assign sts.out_taken = out_full_q && result.ready;
endmodule
`default_nettype wire

// ===== src/iou_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iou_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire iou_pkg::dp_sts_t sts,
	output iou_pkg::ctl_cmd_t cmd
);
	import iou_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_AREA;
			ST_AREA: state_d = sts.skip ? ST_LAST : ST_UNION;
			ST_UNION: state_d = ST_LOG;
			ST_LOG: state_d = ST_LOGWAIT;
			ST_LOGWAIT: if (sts.log_done) state_d = ST_PROD;
			ST_PROD: state_d = ST_ACC;
			ST_ACC: state_d = ST_LAST;
			ST_LAST: state_d = sts.last ? ST_DIV : ST_IDLE;
			ST_DIV: if (sts.div_done) state_d = ST_EMIT;
			ST_EMIT: if (!sts.out_full || sts.out_taken) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_AREA: cmd.area = 1'b1;
			ST_UNION: cmd.uni = 1'b1;
			ST_LOG: cmd.log_start = 1'b1;
			ST_PROD: cmd.prod = 1'b1;
			ST_ACC: cmd.acc = 1'b1;
			ST_LAST: cmd.div_start = sts.last;
			ST_EMIT: cmd.out_load = !sts.out_full || sts.out_taken;
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== src/iou_loss_forward.sv =====
`timescale 1ns / 1ps
`default_nettype none
// IoU loss accumulator, forward pass.
// The pixel channel takes one request of four predicted and four ground-truth
// edge distances plus a last-pixel flag; the result channel gives the mean
// negative log IoU and the count of contributing pixels once per batch.
// One pixel is worked at a time. A pixel skipped for an all-zero box or a
// full count goes from capture through the area step to the batch-end check.
// A contributing pixel computes areas and union, starts both log2 units,
// waits for them, forms the product and accumulates; the wait grows with s
// (0 to 2*DIST_BITS+2), the normalizing shift of the smaller of union and
// intersection in the log2 units, which draw one fraction bit per cycle
// through a 32x32 squaring multiplier. The last pixel then runs the bit-serial
// restoring divide of the sum by the count and loads the output register.
// Reset clears the sum, the count and the controller; no result is pending.
// The output register holds a result until the receiver takes it; pixels are
// still accepted meanwhile, and only a following batch end waits for it.
module iou_loss_forward #(
	parameter int DIST_BITS = 16,
	parameter int COUNT_BITS = 20,
	parameter int LOSS_FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	iou_pix_if.sink pixel,
	iou_res_if.source result
);
	import iou_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t sts;

	iou_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pixel.valid), .in_ready(pixel.ready),
		.sts(sts), .cmd(cmd)
	);

	iou_dp #(
		.DIST_BITS(DIST_BITS), .COUNT_BITS(COUNT_BITS), .LOSS_FRAC_BITS(LOSS_FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.pixel(pixel), .result(result)
	);

	// A result is loaded only for a batch end.
	a_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.last) else $error("result loaded without last pixel");

	// Skipped pixels never reach the accumulator.
	a_acc_skip: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> !sts.skip) else $error("skipped pixel accumulated");

	// A new result appears only after a load command.
	a_rise_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.out_load))
		else $error("result valid without load");
endmodule
`default_nettype wire

// ===== dv/iou_loss_checker.sv =====
`timescale 1ns / 1ps
module iou_loss_checker #(
	parameter int DIST_BITS = 16,
	parameter int COUNT_BITS = 20,
	parameter int LOSS_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	iou_pix_if pixel,
	iou_res_if result,
	output int fail_count,
	output int pending
);
	localparam int LOSS_BITS = 8 + LOSS_FRAC_BITS;
	localparam logic [LOSS_BITS-1:0] TERM_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [LOSS_BITS-1:0] mean_loss;
		logic [COUNT_BITS-1:0] pixel_count;
	} batch_res_t;

	batch_res_t expected_batches[$];
	logic [63:0] loss_acc;
	logic [COUNT_BITS-1:0] pixel_tally;

	// Base-2 logarithm in Q.24 by normalizing and repeated squaring.
	function automatic logic [63:0] log2_q24(logic [63:0] x);
		int msb;
		logic [63:0] m;
		logic [63:0] frac;
		msb = 0;
		frac = 0;
		if (x == 0)
			x = 1;
		for (int k = 0; k < 64; k++)
			if (x[k])
				msb = k;
		m = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
		for (int k = 0; k < 24; k++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (64'(msb) << 24) | frac;
	endfunction

	// Negative log IoU of one pixel, saturated to the loss width.
	function automatic logic [63:0] iou_term(logic [63:0] pt, pb, pl, pr, gt, gb, gl, gr);
		logic [63:0] parea, garea, inter, uni, lu, li, d, t;
		int sh;
		sh = 32 + 24 - LOSS_FRAC_BITS;
		parea = (pt + pb) * (pl + pr);
		garea = (gt + gb) * (gl + gr);
		inter = ((pt < gt ? pt : gt) + (pb < gb ? pb : gb)) *
			((pl < gl ? pl : gl) + (pr < gr ? pr : gr));
		uni = parea + garea - inter;
		if (uni < 1)
			uni = 1;
		if (inter == 0)
			return 64'(TERM_MAX);
		lu = log2_q24(uni);
		li = log2_q24(inter);
		d = (lu > li) ? lu - li : 0;
		t = (d * 64'hB17217F8 + (64'd1 << (sh - 1))) >> sh;
		if (t > 64'(TERM_MAX))
			t = 64'(TERM_MAX);
		return t;
	endfunction

	assign pending = expected_batches.size();

	// Predict on each accepted pixel request and check each result request.
	always @(posedge clk or negedge arst_n) begin
		logic [63:0] pt, pb, pl, pr, gt, gb, gl, gr, mean, div;
		batch_res_t exp_res;
		if (!arst_n) begin
			loss_acc <= 0;
			pixel_tally <= 0;
			fail_count <= 0;
			expected_batches.delete();
		end else begin
			if (pixel.valid && pixel.ready) begin
				pt = pixel.pred_top; pb = pixel.pred_bottom;
				pl = pixel.pred_left; pr = pixel.pred_right;
				gt = pixel.truth_top; gb = pixel.truth_bottom;
				gl = pixel.truth_left; gr = pixel.truth_right;
				mean = loss_acc;
				div = pixel_tally;
				if ((pt | pb | pl | pr) != 0 && (gt | gb | gl | gr) != 0 &&
					pixel_tally != COUNT_MAX) begin
					mean = mean + iou_term(pt, pb, pl, pr, gt, gb, gl, gr);
					div = div + 1;
				end
				if (pixel.last_pixel) begin
					exp_res.pixel_count = div[COUNT_BITS-1:0];
					if (div == 0)
						div = 1;
					mean = mean / div;
					if (mean > 64'(TERM_MAX))
						mean = 64'(TERM_MAX);
					exp_res.mean_loss = mean[LOSS_BITS-1:0];
					expected_batches.push_back(exp_res);
					loss_acc <= 0;
					pixel_tally <= 0;
				end else begin
					loss_acc <= mean;
					pixel_tally <= div[COUNT_BITS-1:0];
				end
			end
			if (result.valid && result.ready) begin
				if (expected_batches.size() == 0) begin
					$display("%0t: unexpected result mean_loss %h pixel_count %0d",
						$time, result.mean_loss, result.pixel_count);
					fail_count <= fail_count + 1;
				end else begin
					exp_res = expected_batches.pop_front();
					if (result.mean_loss !== exp_res.mean_loss ||
						result.pixel_count !== exp_res.pixel_count) begin
						$display("%0t: mismatch expected %h/%0d actual %h/%0d", $time,
							exp_res.mean_loss, exp_res.pixel_count,
							result.mean_loss, result.pixel_count);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== dv/tb_iou_loss_forward.sv =====
`timescale 1ns / 1ps
module tb_iou_loss_forward;
	import iou_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;

	iou_pix_if #(.DIST_BITS(16)) pixel();
	iou_res_if #(.COUNT_BITS(20), .LOSS_FRAC_BITS(16)) result();

	iou_loss_forward dut (.clk(clk), .arst_n(arst_n), .pixel(pixel), .result(result));
	iou_loss_checker chk (.clk(clk), .arst_n(arst_n), .pixel(pixel), .result(result),
		.fail_count(fail_count), .pending(pending));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random according to the current phase.
	always @(posedge clk)
		result.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Drive one pixel request and hold it until it is taken. Valid stays up
	// after the accepting edge; the next request or an idle cycle replaces it.
	task automatic send_pixel(logic [15:0] pt, pb, pl, pr, gt, gb, gl, gr, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel.valid <= 1'b0;
			@(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.pred_top <= pt; pixel.pred_bottom <= pb;
		pixel.pred_left <= pl; pixel.pred_right <= pr;
		pixel.truth_top <= gt; pixel.truth_bottom <= gb;
		pixel.truth_left <= gl; pixel.truth_right <= gr;
		pixel.last_pixel <= last;
		do
			@(posedge clk);
		while (!pixel.ready);
	endtask

	// Distances mostly of moderate size, sometimes zero or full range.
	function automatic logic [15:0] rand_dist();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'($urandom);
			2: return 16'hFFFF - 16'($urandom_range(3));
			default: return 16'($urandom_range(4000));
		endcase
	endfunction

	task automatic random_pixel(int last_pct);
		logic [15:0] d[8];
		logic both;
		both = ($urandom_range(9) == 0);
		foreach (d[i])
			d[i] = rand_dist();
		// Sometimes the ground truth sits right on the prediction.
		if (both)
			for (int i = 0; i < 4; i++)
				d[i+4] = d[i];
		send_pixel(d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7],
			$urandom_range(99) < last_pct);
	endtask

	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pixel.valid = 1'b0;
		pixel.pred_top = '0; pixel.pred_bottom = '0;
		pixel.pred_left = '0; pixel.pred_right = '0;
		pixel.truth_top = '0; pixel.truth_bottom = '0;
		pixel.truth_left = '0; pixel.truth_right = '0;
		pixel.last_pixel = 1'b0;
		result.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty batch, skipped boxes, zero intersection, extremes.
		send_pixel(0, 0, 0, 0, 0, 0, 0, 0, 1);
		send_pixel(0, 0, 0, 0, 5, 5, 5, 5, 0);
		send_pixel(5, 5, 5, 5, 0, 0, 0, 0, 1);
		send_pixel(16, 16, 16, 16, 16, 16, 16, 16, 1);
		send_pixel(16, 0, 16, 0, 0, 16, 0, 16, 1);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 1, 0, 0);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
		send_pixel(1, 0, 0, 1, 16'hFFFF, 0, 0, 16'hFFFF, 0);
		send_pixel(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
			16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 0);
		send_pixel(30, 10, 20, 40, 10, 30, 40, 20, 0);
		send_pixel(1, 1, 1, 1, 2, 2, 2, 2, 1);
		send_pixel(100, 0, 0, 100, 0, 100, 100, 0, 1);

		// Random batches through the idling phases.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 66; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 66; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			for (int n = 0; n < 135; n++)
				random_pixel(phase == 2 ? 25 : 12);
			// Hold off until every pending result has been taken.
			if (phase == 1) begin
				pixel.valid <= 1'b0;
				while (pending != 0)
					@(posedge clk);
			end
		end
		send_pixel(7, 7, 7, 7, 8, 8, 8, 8, 1);
		pixel.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== files.f =====
src/iou_pkg.sv
src/iou_pix_if.sv
src/iou_res_if.sv
src/iou_log2.sv
src/iou_dp.sv
src/iou_ctrl.sv
src/iou_loss_forward.sv
dv/iou_loss_checker.sv
dv/tb_iou_loss_forward.sv
